FILE: design/ckrr_pkg.sv
// Package for the color-key run extractor: pixel, result and config types,
// register indexes and reset values. Depends on nothing.
package ckrr_pkg;

  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 13;
  localparam int QueueDepth = 2;

  localparam logic [7:0]  TOLERANCE_RST = 8'd16;
  localparam logic [12:0] DIM_RST       = 13'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_RED        = 3'd0,
    CFG_KEY_GREEN      = 3'd1,
    CFG_KEY_BLUE       = 3'd2,
    CFG_TOLERANCE      = 3'd3,
    CFG_KEY_FROM_FIRST = 3'd4,
    CFG_IMAGE_WIDTH    = 3'd5,
    CFG_IMAGE_HEIGHT   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  typedef struct packed {
    logic        rect_valid;
    logic [11:0] run_start;
    logic [12:0] run_end;
    logic [11:0] run_row;
    logic        batch_end;
    logic        frame_end;
    logic [12:0] bound_left;
    logic [12:0] bound_top;
    logic [12:0] bound_right;
    logic [12:0] bound_bottom;
  } rect_t;

  typedef struct packed {
    logic [7:0]  key_red;
    logic [7:0]  key_green;
    logic [7:0]  key_blue;
    logic [7:0]  tolerance;
    logic        key_from_first;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

endpackage

FILE: design/ckrr_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Used for the pixel input and the rectangle output; no dependencies.
interface ckrr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/ckrr_front.sv
// Front end: raster position, key selection, transparency test and run
// tracking. Pushes one run event per closed run or frame end. Uses ckrr_pkg.
module ckrr_front
  import ckrr_pkg::*;
#(
  parameter int MaxDim = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cfg_t                              cfg_i,
  input  logic                              pix_valid_i,
  input  pixel_t                            pix_i,
  output logic                              pix_ready_o,
  input  logic                              full_i,
  output logic                              push_o,
  output logic [2*$clog2(MaxDim)+$clog2(MaxDim+1)+1:0] item_o
);

  localparam int CW = $clog2(MaxDim);
  localparam int DW = $clog2(MaxDim + 1);
  localparam int LW = (DW > CfgDataW) ? DW : CfgDataW;

  typedef struct packed {
    logic          emit;
    logic [CW-1:0] start;
    logic [DW-1:0] stop;
    logic [CW-1:0] row;
    logic          fend;
  } run_item_t;

  function automatic logic in_band(input logic [7:0] c, input logic [7:0] lo,
                                   input logic [7:0] tol);
    logic [8:0] hi;
    hi = {1'b0, lo} + {1'b0, tol};
    if (hi > 9'd255) hi = 9'd255;
    return (c >= lo) && ({1'b0, c} <= hi);
  endfunction

  function automatic logic [LW-1:0] clamp_dim(input logic [CfgDataW-1:0] v);
    logic [LW-1:0] x;
    x = LW'(v);
    if (x == '0) x = LW'(1);
    else if (x > LW'(MaxDim)) x = LW'(MaxDim);
    return x;
  endfunction

  logic [CW-1:0] col_q, col_d, row_q, row_d, open_q, open_d;
  logic          in_run_q, in_run_d;
  logic [23:0]   cap_q, cap_d;

  logic          accept, origin, last_col, last_row, clear, emit;
  logic [23:0]   key;
  logic [LW-1:0] w_eff, h_eff;
  run_item_t     item;

  assign pix_ready_o = !full_i;
  assign accept      = pix_valid_i && !full_i;
  assign origin      = (col_q == '0) && (row_q == '0);
  assign w_eff       = clamp_dim(cfg_i.image_width);
  assign h_eff       = clamp_dim(cfg_i.image_height);
  assign last_col    = LW'(col_q) >= (w_eff - LW'(1));
  assign last_row    = LW'(row_q) >= (h_eff - LW'(1));

  always_comb begin
    if (cfg_i.key_from_first) begin
      key = origin ? {pix_i.pixel_red, pix_i.pixel_green, pix_i.pixel_blue} : cap_q;
    end else begin
      key = {cfg_i.key_red, cfg_i.key_green, cfg_i.key_blue};
    end
    clear = in_band(pix_i.pixel_red,   key[23:16], cfg_i.tolerance) &&
            in_band(pix_i.pixel_green, key[15:8],  cfg_i.tolerance) &&
            in_band(pix_i.pixel_blue,  key[7:0],   cfg_i.tolerance);
  end

  always_comb begin
    emit = clear ? in_run_q : last_col;
    item = '0;
    item.emit = emit;
    item.fend = last_col && last_row;
    if (emit) begin
      item.start = in_run_q ? open_q : col_q;
      item.stop  = clear ? DW'(col_q) : DW'(col_q) + DW'(1);
      item.row   = row_q;
    end

    col_d    = col_q;
    row_d    = row_q;
    in_run_d = in_run_q;
    open_d   = open_q;
    cap_d    = cap_q;
    if (accept) begin
      if (cfg_i.key_from_first && origin) cap_d = key;
      if (!clear && !in_run_q) open_d = col_q;
      in_run_d = !clear && !last_col;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  assign push_o = accept && (item.emit || item.fend);
  assign item_o = item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      in_run_q <= 1'b0;
      open_q   <= '0;
      cap_q    <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      in_run_q <= in_run_d;
      open_q   <= open_d;
      cap_q    <= cap_d;
    end
  end

endmodule

FILE: design/ckrr_queue.sv
// Small FIFO of run events between front and back end.
// Uses ckrr_pkg for the depth.
module ckrr_queue
  import ckrr_pkg::*;
#(
  parameter int Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int PW = $clog2(QueueDepth);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;

  assign full_o  = cnt_q == (PW+1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(QueueDepth - 1)) ? '0 : wr_q + PW'(1);
      if (pop_i)  rd_q <= (rd_q == PW'(QueueDepth - 1)) ? '0 : rd_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

FILE: design/ckrr_back.sv
// Back end: batch count and bounding box, result formatting and the
// output register. Uses ckrr_pkg.
module ckrr_back
  import ckrr_pkg::*;
#(
  parameter int MaxDim     = 4096,
  parameter int BatchLimit = 2000
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  head_valid_i,
  input  logic [2*$clog2(MaxDim)+$clog2(MaxDim+1)+1:0] head_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output rect_t out_o
);

  localparam int CW = $clog2(MaxDim);
  localparam int DW = $clog2(MaxDim + 1);
  localparam int BW = $clog2(BatchLimit + 1);

  typedef struct packed {
    logic          emit;
    logic [CW-1:0] start;
    logic [DW-1:0] stop;
    logic [CW-1:0] row;
    logic          fend;
  } run_item_t;

  run_item_t     head;
  logic [BW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [DW-1:0] left_q, top_q, right_q, bottom_q;
  logic [DW-1:0] left_n, top_n, right_n, bottom_n, bot_row;
  logic          out_valid_q, bend;
  rect_t         out_q;

  assign head    = head_i;
  assign pop_o   = head_valid_i && (!out_valid_q || out_ready_i);
  assign cnt_inc = cnt_q + BW'(1);
  assign bot_row = DW'(head.row) + DW'(1);

  always_comb begin
    left_n   = left_q;
    top_n    = top_q;
    right_n  = right_q;
    bottom_n = bottom_q;
    cnt_d    = cnt_q;
    bend     = 1'b0;
    if (head.emit) begin
      cnt_d = cnt_inc;
      bend  = cnt_inc >= BW'(BatchLimit);
      if (DW'(head.start) < left_q) left_n = DW'(head.start);
      if (DW'(head.row) < top_q)    top_n  = DW'(head.row);
      if (head.stop > right_q)      right_n = head.stop;
      if (bot_row > bottom_q)       bottom_n = bot_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.rect_valid   <= head.emit;
      out_q.run_start    <= 12'(head.start);
      out_q.run_end      <= 13'(head.stop);
      out_q.run_row      <= 12'(head.row);
      out_q.batch_end    <= bend;
      out_q.frame_end    <= head.fend;
      out_q.bound_left   <= 13'(left_n);
      out_q.bound_top    <= 13'(top_n);
      out_q.bound_right  <= 13'(right_n);
      out_q.bound_bottom <= 13'(bottom_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      left_q      <= DW'(MaxDim);
      top_q       <= DW'(MaxDim);
      right_q     <= '0;
      bottom_q    <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        if (bend || head.fend) begin
          // batch closes: fresh count and empty box
          cnt_q    <= '0;
          left_q   <= DW'(MaxDim);
          top_q    <= DW'(MaxDim);
          right_q  <= '0;
          bottom_q <= '0;
        end else begin
          cnt_q    <= cnt_d;
          left_q   <= left_n;
          top_q    <= top_n;
          right_q  <= right_n;
          bottom_q <= bottom_n;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: design/color_key_run_rectangles.sv
// Top level of the color-key run extractor: config registers, front end,
// run event queue and back end. Depends on ckrr_pkg, ckrr_stream_if and the
// ckrr_front, ckrr_queue and ckrr_back modules.
//
//   channel   dir  payload   notes
//   pix_i     in   pixel_t   one pixel per transaction, raster order
//   rect_o    out  rect_t    one per closed run or frame end
//   cfg_*     in   13 bits   write-only register port, index 0..6
//
// One pixel per cycle sustained while the queue is not full; a result goes to
// the queue at the accepting edge, then to the back end output register.
// Pixels that close no run and do not end the frame produce nothing.
// A stall on rect_o fills the two-entry queue, then pix_i.ready drops.
// Reset clears position, run, batch and key state; registers take their
// reset values.
module color_key_run_rectangles
  import ckrr_pkg::*;
#(
  parameter int MAX_DIM     = 4096,
  parameter int BATCH_LIMIT = 2000
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ckrr_stream_if.sink         pix_i,
  ckrr_stream_if.source       rect_o
);

  localparam int ItemW = 2 * $clog2(MAX_DIM) + $clog2(MAX_DIM + 1) + 2;

  cfg_t             cfg_q, cfg_d;
  logic             q_full, q_push, q_pop, q_valid;
  logic [ItemW-1:0] q_in, q_out;
  pixel_t           pix;
  rect_t            rect;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_RED:        cfg_d.key_red        = cfg_data_i[7:0];
        CFG_KEY_GREEN:      cfg_d.key_green      = cfg_data_i[7:0];
        CFG_KEY_BLUE:       cfg_d.key_blue       = cfg_data_i[7:0];
        CFG_TOLERANCE:      cfg_d.tolerance      = cfg_data_i[7:0];
        CFG_KEY_FROM_FIRST: cfg_d.key_from_first = cfg_data_i[0];
        CFG_IMAGE_WIDTH:    cfg_d.image_width    = cfg_data_i;
        CFG_IMAGE_HEIGHT:   cfg_d.image_height   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_red        <= '0;
      cfg_q.key_green      <= '0;
      cfg_q.key_blue       <= '0;
      cfg_q.tolerance      <= TOLERANCE_RST;
      cfg_q.key_from_first <= 1'b1;
      cfg_q.image_width    <= DIM_RST;
      cfg_q.image_height   <= DIM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign pix = pix_i.payload;

  ckrr_front #(
    .MaxDim (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_valid_i (pix_i.valid),
    .pix_i       (pix),
    .pix_ready_o (pix_i.ready),
    .full_i      (q_full),
    .push_o      (q_push),
    .item_o      (q_in)
  );

  ckrr_queue #(
    .Width (ItemW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  ckrr_back #(
    .MaxDim     (MAX_DIM),
    .BatchLimit (BATCH_LIMIT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_out),
    .pop_o        (q_pop),
    .out_valid_o  (rect_o.valid),
    .out_ready_i  (rect_o.ready),
    .out_o        (rect)
  );

  assign rect_o.payload = rect;

endmodule
